FILE: src/button_click_classifier_top_macros.svh
// Assertion macros shared by the button click classifier RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button click classifier: implication violated");

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button click classifier: next-cycle implication violated");

`endif

FILE: src/bcc_pkg.sv
// Package for the button click classifier: widths, limits, register codes,
// and the configuration and result structs. Depends on nothing.
package bcc_pkg;

  localparam int TIME_W = 31;
  localparam int EL_W   = 20;
  localparam int CNT_W  = 8;
  localparam int CIDX_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [TIME_W-1:0] LONG_PRESS_RST  = TIME_W'(3000000);
  localparam logic [TIME_W-1:0] ANTI_BOUNCE_RST = TIME_W'(30000);
  localparam logic [TIME_W-1:0] RELEASE_GAP_RST = TIME_W'(120000);

  typedef enum logic [CIDX_W-1:0] {
    CFG_LONG_PRESS  = 2'd0,
    CFG_ANTI_BOUNCE = 2'd1,
    CFG_RELEASE_GAP = 2'd2,
    CFG_ENABLED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] long_press_time;
    logic [TIME_W-1:0] anti_bounce_time;
    logic [TIME_W-1:0] release_gap;
    logic              enabled;
  } cfg_t;

  typedef struct packed {
    logic              press_event;
    logic              long_press_event;
    logic              click_event;
    logic              double_click_event;
    logic              multi_click_event;
    logic [CNT_W-1:0]  click_total;
    logic              release_event;
    logic [TIME_W-1:0] hold_duration;
  } result_t;

endpackage

FILE: src/bcc_core.sv
// Classification logic and button state registers of the click classifier.
// Depends on bcc_pkg and the shared assertion macros.
`include "button_click_classifier_top_macros.svh"

module bcc_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic                     pressed,
  input  logic [bcc_pkg::EL_W-1:0] elapsed_us,
  input  bcc_pkg::cfg_t            cfg,
  output bcc_pkg::result_t         res
);
  import bcc_pkg::*;

  logic              press_announced_r, press_announced_nxt;
  logic [TIME_W-1:0] hold_time_r, hold_time_nxt;
  logic [TIME_W-1:0] last_hold_time_r, last_hold_time_nxt;
  logic              long_announced_r, long_announced_nxt;
  logic [TIME_W-1:0] release_time_r, release_time_nxt;
  logic              click_pending_r, click_pending_nxt;
  logic [CNT_W-1:0]  click_counter_r, click_counter_nxt;
  logic              release_announced_r, release_announced_nxt;

  logic [TIME_W:0]   hold_sum, rel_sum;
  logic [TIME_W-1:0] hold_acc, rel_acc;
  logic [CNT_W-1:0]  cnt_inc, cnt_tmp;
  logic              is_click, pend_tmp, gap_hit;

  assign hold_sum = {1'b0, hold_time_r} + {{(TIME_W+1-EL_W){1'b0}}, elapsed_us};
  assign rel_sum  = {1'b0, release_time_r} + {{(TIME_W+1-EL_W){1'b0}}, elapsed_us};
  assign hold_acc = hold_sum[TIME_W] ? TIME_MAX : hold_sum[TIME_W-1:0];
  assign rel_acc  = rel_sum[TIME_W] ? TIME_MAX : rel_sum[TIME_W-1:0];
  assign is_click = (hold_time_r > cfg.anti_bounce_time) &&
                    (hold_time_r < cfg.long_press_time);
  assign cnt_inc  = (click_counter_r != COUNT_MAX) ? click_counter_r + CNT_W'(1)
                                                   : click_counter_r;
  assign cnt_tmp  = is_click ? cnt_inc : click_counter_r;
  assign pend_tmp = click_pending_r | is_click;
  assign gap_hit  = rel_acc > cfg.release_gap;

  always_comb begin
    press_announced_nxt   = press_announced_r;
    hold_time_nxt         = hold_time_r;
    last_hold_time_nxt    = last_hold_time_r;
    long_announced_nxt    = long_announced_r;
    release_time_nxt      = release_time_r;
    click_pending_nxt     = click_pending_r;
    click_counter_nxt     = click_counter_r;
    release_announced_nxt = release_announced_r;
    res                   = '0;
    if (cfg.enabled) begin
      if (pressed) begin
        if (!press_announced_r) begin
          press_announced_nxt = 1'b1;
          res.press_event     = 1'b1;
        end
        hold_time_nxt      = hold_acc;
        last_hold_time_nxt = hold_acc;
        if ((hold_acc > cfg.long_press_time) && !long_announced_r) begin
          long_announced_nxt   = 1'b1;
          res.long_press_event = 1'b1;
          click_counter_nxt    = '0;
          click_pending_nxt    = 1'b0;
        end
        release_announced_nxt = 1'b0;
        release_time_nxt      = '0;
      end else begin
        press_announced_nxt = 1'b0;
        click_pending_nxt   = pend_tmp;
        click_counter_nxt   = cnt_tmp;
        release_time_nxt    = rel_acc;
        if (pend_tmp && gap_hit) begin
          res.click_event        = (cnt_tmp < CNT_W'(2));
          res.double_click_event = !(cnt_tmp < CNT_W'(2));
          res.multi_click_event  = 1'b1;
          res.click_total        = cnt_tmp;
          click_pending_nxt      = 1'b0;
          click_counter_nxt      = '0;
        end
        if (gap_hit && !release_announced_r) begin
          release_announced_nxt = 1'b1;
          res.release_event     = 1'b1;
          res.hold_duration     = last_hold_time_r;
        end
        hold_time_nxt      = '0;
        long_announced_nxt = 1'b0;
      end
    end else begin
      hold_time_nxt      = '0;
      long_announced_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_announced_r   <= 1'b0;
      hold_time_r         <= '0;
      last_hold_time_r    <= '0;
      long_announced_r    <= 1'b0;
      release_time_r      <= '0;
      click_pending_r     <= 1'b0;
      click_counter_r     <= '0;
      release_announced_r <= 1'b1;
    end else if (in_fire) begin
      press_announced_r   <= press_announced_nxt;
      hold_time_r         <= hold_time_nxt;
      last_hold_time_r    <= last_hold_time_nxt;
      long_announced_r    <= long_announced_nxt;
      release_time_r      <= release_time_nxt;
      click_pending_r     <= click_pending_nxt;
      click_counter_r     <= click_counter_nxt;
      release_announced_r <= release_announced_nxt;
    end
  end

  `BCC_ASSERT_IMP(a_long_needs_press, long_announced_r, press_announced_r)
  `BCC_ASSERT_IMP(a_pending_has_count, click_pending_r, click_counter_r != '0)
  `BCC_ASSERT_IMP(a_run_report, in_fire && res.multi_click_event,
                  (res.click_total != '0) && (res.click_event != res.double_click_event))
  `BCC_ASSERT_NXT(a_disable_clears, in_fire && !cfg.enabled,
                  (hold_time_r == '0) && !long_announced_r)

endmodule

FILE: src/bcc_outbuf.sv
// Result register with a skid stage for the click classifier output channel.
// Depends on bcc_pkg and the shared assertion macros.
`include "button_click_classifier_top_macros.svh"

module bcc_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  bcc_pkg::result_t res,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bcc_pkg::result_t out_res
);
  import bcc_pkg::*;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    out_fire;

  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r && out_fire) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid_r || out_fire) begin
          out_data_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BCC_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BCC_ASSERT_NXT(a_no_lost_result, out_valid_r && !out_ready, out_valid_r)
  `BCC_ASSERT_NXT(a_skid_drains, skid_valid_r && out_fire, !skid_valid_r && out_valid_r)

endmodule

FILE: src/button_click_classifier_top.sv
// Top level of the button click classifier: configuration registers and the
// classifier core feeding the result buffer. Depends on bcc_pkg, bcc_core, bcc_outbuf.
//
// Usage: each input item is one sample of the button level (in_pressed) plus the
// microseconds since the previous sample (in_elapsed_us), sent over a valid/ready
// channel. Every accepted item yields exactly one result item on the out_ channel
// carrying the press, long-press, click, double/multi-click and release flags.
// Results are registered in the output buffer. Throughput is one item per cycle while
// in_ready is high; the whole classification is a single pass of a 31-bit saturating
// add followed by a compare against the limits. When the receiver stalls, the result
// register holds and a skid stage takes one more item; in_ready drops only while the
// skid stage is full. The cfg_ channel writes the four registers (long press time,
// anti-bounce time, release gap, enable) by index; cfg_ready is always high. The user
// must make writes only while the block is idle; the block does not enforce it.
// Synchronous reset loads the default limits, enables detection, clears the button
// state but sets the release flag, and empties the output buffers.
module button_click_classifier_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_pressed,
  input  logic [bcc_pkg::EL_W-1:0]    in_elapsed_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_press_event,
  output logic                        out_long_press_event,
  output logic                        out_click_event,
  output logic                        out_double_click_event,
  output logic                        out_multi_click_event,
  output logic [bcc_pkg::CNT_W-1:0]   out_click_total,
  output logic                        out_release_event,
  output logic [bcc_pkg::TIME_W-1:0]  out_hold_duration,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bcc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bcc_pkg::TIME_W-1:0]  cfg_data
);
  import bcc_pkg::*;

  cfg_t    cfg_r;
  result_t res, out_res;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_time  <= LONG_PRESS_RST;
      cfg_r.anti_bounce_time <= ANTI_BOUNCE_RST;
      cfg_r.release_gap      <= RELEASE_GAP_RST;
      cfg_r.enabled          <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LONG_PRESS:  cfg_r.long_press_time  <= cfg_data;
        CFG_ANTI_BOUNCE: cfg_r.anti_bounce_time <= cfg_data;
        CFG_RELEASE_GAP: cfg_r.release_gap      <= cfg_data;
        CFG_ENABLED:     cfg_r.enabled          <= cfg_data[0];
        default:         cfg_r                  <= cfg_r;
      endcase
    end
  end

  bcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .pressed    (in_pressed),
    .elapsed_us (in_elapsed_us),
    .cfg        (cfg_r),
    .res        (res)
  );

  bcc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_press_event        = out_res.press_event;
  assign out_long_press_event   = out_res.long_press_event;
  assign out_click_event        = out_res.click_event;
  assign out_double_click_event = out_res.double_click_event;
  assign out_multi_click_event  = out_res.multi_click_event;
  assign out_click_total        = out_res.click_total;
  assign out_release_event      = out_res.release_event;
  assign out_hold_duration      = out_res.hold_duration;

endmodule
